/* src/mvd_pkg.sv */
// Package for the Minkowski vector distance unit: types, codes, constants.
// No dependencies.
package mvd_pkg;
  localparam int MaxDimDefault = 1024;
  localparam int CoordW = 10;
  localparam int DistW = 20;
  localparam int AccW = 64;
  localparam int DiffW = 10;

  typedef enum logic [1:0] {
    MODE_L1 = 2'd0,
    MODE_L2 = 2'd1,
    MODE_L5 = 2'd2,
    MODE_LINF = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW,
    ST_FOLD,
    ST_ROOT_TRY,
    ST_ROOT_POW,
    ST_ROOT_CMP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;      // latch input word, form |a-b|
    logic pow_step;  // multiply product by d
    logic fold;      // fold product into accumulator
    logic root_init; // start root search
    logic root_try;  // form candidate, product := 1
    logic root_mul;  // product *= candidate
    logic root_cmp;  // compare and keep bit
    logic out_load;  // form result, clear accumulator
  } cmd_t;

  typedef struct packed {
    logic pow_done;
    logic root_pow_done;
    logic root_bits_done;
    logic last;
    mode_t mode;
  } stat_t;
endpackage

/* src/mvd_if.sv */
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface mvd_if #(parameter int W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* src/mvd_ctrl.sv */
// Controller state machine of the distance unit.
// Depends on mvd_pkg.
module mvd_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_full,
  input  mvd_pkg::stat_t st,
  output mvd_pkg::cmd_t cmd
);
  import mvd_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_POW;
        end
      end
      ST_POW: begin
        if (st.pow_done) state_nxt = ST_FOLD;
        else cmd.pow_step = 1'b1;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (!st.last) state_nxt = ST_IDLE;
        else if (st.mode == MODE_L2 || st.mode == MODE_L5) begin
          state_nxt = ST_ROOT_TRY;
        end else state_nxt = ST_OUT;
      end
      ST_ROOT_TRY: begin
        cmd.root_try = 1'b1;
        state_nxt = ST_ROOT_POW;
      end
      ST_ROOT_POW: begin
        if (st.root_pow_done) state_nxt = ST_ROOT_CMP;
        else cmd.root_mul = 1'b1;
      end
      ST_ROOT_CMP: begin
        cmd.root_cmp = 1'b1;
        state_nxt = st.root_bits_done ? ST_OUT : ST_ROOT_TRY;
      end
      ST_OUT: begin
        if (!out_full) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // Root search state is initialised on every fold, whether or not the word is last.
    cmd.root_init = cmd.fold;
  end
endmodule

/* src/mvd_dp.sv */
// Datapath of the distance unit: shared multiplier, saturating accumulator,
// bit-by-bit root search and output register. Depends on mvd_pkg.
module mvd_dp (
  input  logic clk,
  input  logic rst_n,
  input  logic [mvd_pkg::CoordW-1:0] in_a,
  input  logic [mvd_pkg::CoordW-1:0] in_b,
  input  logic in_last,
  input  logic [1:0] mode,
  input  mvd_pkg::cmd_t cmd,
  output mvd_pkg::stat_t st,
  input  logic out_ready,
  output logic out_valid,
  output logic [mvd_pkg::DistW-1:0] out_dist,
  output logic out_ovf
);
  import mvd_pkg::*;

  logic [DiffW-1:0] d_r;
  logic last_r;
  mode_t emode_r;
  logic [AccW-1:0] prod_r;     // 50-bit max for d^5, roots bounded by acc
  logic [2:0] pcnt_r;
  logic [AccW-1:0] acc_r;
  logic sat_r;
  logic [31:0] root_r, cand_r;
  logic [4:0] bit_r;
  logic big_r;                 // candidate power already exceeds accumulator
  logic half_r;                // low half of a wide candidate already multiplied
  logic [AccW+15:0] part_r;    // product with the candidate's low half
  logic ovalid_r;
  logic [DistW-1:0] odist_r;
  logic oovf_r;

  logic signed [CoordW:0] diff;
  logic [2:0] need;
  logic [AccW:0] sum;
  logic [15:0] mul_op;
  logic [AccW+15:0] mul_part;
  logic [AccW+31:0] mul_full;
  logic [AccW-1:0] res;

  assign diff = $signed({in_a[CoordW-1], in_a}) - $signed({in_b[CoordW-1], in_b});
  assign need = (emode_r == MODE_L2) ? 3'd2 : (emode_r == MODE_L5) ? 3'd5 : 3'd1;
  // 64 x 16 multiplier; a candidate wider than 16 bits takes two passes
  assign mul_op = cmd.pow_step ? {6'd0, d_r} : (half_r ? cand_r[31:16] : cand_r[15:0]);
  assign mul_part = {16'd0, prod_r} * {64'd0, mul_op};
  assign mul_full = half_r ? ({mul_part, 16'd0} + {16'd0, part_r}) : {16'd0, mul_part};
  assign sum = {1'b0, acc_r} + {1'b0, prod_r};

  assign st.pow_done = (pcnt_r == need);
  assign st.root_pow_done = (pcnt_r == need) || big_r;
  assign st.root_bits_done = (bit_r == 5'd0);
  assign st.last = last_r;
  assign st.mode = mode_t'(mode);

  always_comb begin
    unique case (mode_t'(mode))
      MODE_L2, MODE_L5: res = {32'd0, root_r};
      default: res = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      sat_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        d_r <= diff[CoordW] ? DiffW'(-diff) : DiffW'(diff);
        last_r <= in_last;
        emode_r <= mode_t'(mode);
        prod_r <= 64'd1;
        pcnt_r <= 3'd0;
        half_r <= 1'b0;
      end
      if (cmd.pow_step) begin
        prod_r <= mul_full[AccW-1:0];
        pcnt_r <= pcnt_r + 3'd1;
      end
      if (cmd.fold) begin
        if (emode_r == MODE_LINF) begin
          if ({54'd0, d_r} > acc_r) acc_r <= {54'd0, d_r};
        end else if (sum[AccW]) begin
          acc_r <= '1;
          sat_r <= 1'b1;
        end else acc_r <= sum[AccW-1:0];
      end
      if (cmd.root_init) begin
        root_r <= '0;
        bit_r <= (mode_t'(mode) == MODE_L2) ? 5'd31 : 5'd12;
        emode_r <= mode_t'(mode);
      end
      if (cmd.root_try) begin
        cand_r <= root_r | (32'd1 << bit_r);
        prod_r <= 64'd1;
        pcnt_r <= 3'd0;
        big_r <= 1'b0;
        half_r <= 1'b0;
      end
      if (cmd.root_mul) begin
        if (!half_r && cand_r[31:16] != '0) begin
          // hold the low-half product, finish with the high half next cycle
          part_r <= mul_part;
          half_r <= 1'b1;
        end else begin
          prod_r <= mul_full[AccW-1:0];
          pcnt_r <= pcnt_r + 3'd1;
          half_r <= 1'b0;
          if (mul_full[AccW+31:AccW] != '0 || mul_full[AccW-1:0] > acc_r) big_r <= 1'b1;
        end
      end
      if (cmd.root_cmp) begin
        if (!big_r && prod_r <= acc_r) root_r <= cand_r;
        bit_r <= bit_r - 5'd1;
      end
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      if (cmd.out_load) begin
        ovalid_r <= 1'b1;
        if (res > 64'(20'hFFFFF)) begin
          odist_r <= '1;
          oovf_r <= 1'b1;
        end else begin
          odist_r <= res[DistW-1:0];
          oovf_r <= sat_r;
        end
        acc_r <= '0;
        sat_r <= 1'b0;
      end
    end
  end

  assign out_valid = ovalid_r;
  assign out_dist = odist_r;
  assign out_ovf = oovf_r;
endmodule

/* src/minkowski_vector_distance_unit.sv */
// Top level of the Minkowski vector distance unit (L1, L2, L5, L-infinity).
// Depends on mvd_pkg, mvd_if, mvd_ctrl and mvd_dp.
//
//  channel | dir | word
//  in_     | in  | element_a[9:0], element_b[9:0], last_element
//  out_    | out | distance[19:0], overflow
//  cfg_    | in  | metric_mode[1:0]
//
// Each word's |a-b| is raised to the power by the one shared multiplier,
// one multiply per cycle.
// A last word adds the root search: 32 bits for L2 (wide candidates take
// two multiplier passes), 13 bits for L5, with fewer multiplies per bit
// when a candidate power overshoots early.
// Reset (rst_n low, synchronous) clears accumulator, flag, mode to L2.
// A pending result waits in the output register; the unit stalls only
// when a second result is ready before the first is taken.
module minkowski_vector_distance_unit (
  input logic clk,
  input logic rst_n,
  mvd_if.sink in_ch,
  mvd_if.source out_ch,
  mvd_if.sink cfg_ch
);
  import mvd_pkg::*;

  logic [1:0] mode_r;
  cmd_t cmd;
  stat_t st;
  logic out_v;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= MODE_L2;
    else if (cfg_ch.valid) mode_r <= cfg_ch.data[1:0];
  end

  mvd_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_full(out_v && !out_ch.ready),
    .st, .cmd
  );

  mvd_dp u_dp (
    .clk, .rst_n,
    .in_a(in_ch.data[20:11]), .in_b(in_ch.data[10:1]), .in_last(in_ch.data[0]),
    .mode(mode_r), .cmd, .st,
    .out_ready(out_ch.ready), .out_valid(out_v),
    .out_dist(out_ch.data[20:1]), .out_ovf(out_ch.data[0])
  );
  assign out_ch.valid = out_v;
endmodule

/* src/mvd_checker.sv */
// Port-level checker for the distance unit, bound to the top level.
// Depends on the top level's ports only.
module mvd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [20:0] out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out word dropped");
  a_no_in_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accepted twice in a row");
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_data)) else $error("out word unknown");
  a_no_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("out valid after reset");
endmodule

bind minkowski_vector_distance_unit mvd_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
